// ===== src/bpw_pkg.sv =====
`default_nettype none
package bpw_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int WIN_BITS    = 32;
	localparam int KB_SHIFT    = 10;
	localparam int COMP_BITS   = 8;
	localparam int COORD_W     = 16;
	localparam int SCR_W       = 12;
	localparam int PITCH_W     = 16;
	localparam int BPP_W       = 3;
	localparam int KB_W        = 7;
	localparam int LAYOUT_W    = 30;
	localparam int BANK_W      = 16;
	localparam int WOFF_W      = 16;
	localparam int SUM_W       = 32;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 30;

	// bank divider works on offset / 1024, one quotient bit per cycle
	localparam int DIV_W       = OFFSET_BITS - KB_SHIFT;
	localparam int DIV_CNT_W   = $clog2(DIV_W);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SCR_W-1:0]    RST_SCREEN_WIDTH  = 12'd640;
	localparam logic [SCR_W-1:0]    RST_SCREEN_HEIGHT = 12'd480;
	localparam logic [PITCH_W-1:0]  RST_LINE_PITCH    = 16'd1280;
	localparam logic [BPP_W-1:0]    RST_BPP           = 3'd2;
	localparam logic [KB_W-1:0]     RST_GRANULE_KB    = 7'd64;
	localparam logic [KB_W-1:0]     RST_WINDOW_KB     = 7'd64;
	localparam logic [LAYOUT_W-1:0] RST_COLOR_LAYOUT  = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH,
		CFG_SCREEN_HEIGHT,
		CFG_LINE_PITCH,
		CFG_BYTES_PER_PIXEL,
		CFG_GRANULE_KB,
		CFG_WINDOW_KB,
		CFG_COLOR_LAYOUT
	} cfg_idx_t;

	typedef struct packed {
		logic [SCR_W-1:0]    screen_width;
		logic [SCR_W-1:0]    screen_height;
		logic [PITCH_W-1:0]  line_pitch;
		logic [BPP_W-1:0]    bytes_per_pixel;
		logic [KB_W-1:0]     granule_kb;
		logic [KB_W-1:0]     window_kb;
		logic [LAYOUT_W-1:0] color_layout;
	} bpw_cfg_t;

	typedef struct packed {
		logic [31:0]            color;
		logic [BPP_W-1:0]       bpp;
		logic [OFFSET_BITS-1:0] offset;
	} bpw_item_t;

	typedef struct packed {
		logic      valid;
		bpw_item_t item;
	} bpw_push_t;

	typedef struct packed {
		logic      not_empty;
		bpw_item_t item;
	} bpw_head_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_EMIT
	} back_state_t;

	function automatic logic [31:0] place_component(
		input logic [COMP_BITS-1:0] value,
		input logic [4:0]           pos,
		input logic [4:0]           size
	);
		logic [4:0]           sz;
		logic [COMP_BITS-1:0] v;
		sz = (size > 5'(COMP_BITS)) ? 5'(COMP_BITS) : size;
		v  = value >> (5'(COMP_BITS) - sz);
		if (sz == 5'd0) begin
			return '0;
		end
		return {24'd0, v} << pos;
	endfunction

endpackage
`default_nettype wire

// ===== src/bpw_pixel_if.sv =====
`default_nettype none
interface bpw_pixel_if;
	import bpw_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	modport source (output valid, pos_x, pos_y, red, green, blue, input ready);
	modport sink   (input valid, pos_x, pos_y, red, green, blue, output ready);
endinterface
`default_nettype wire

// ===== src/bpw_result_if.sv =====
`default_nettype none
interface bpw_result_if;
	import bpw_pkg::*;
	logic              valid;
	logic              ready;
	logic [31:0]       pixel_word;
	logic [BPP_W-1:0]  byte_count;
	logic [WOFF_W-1:0] window_offset;
	logic [BANK_W-1:0] bank_number;
	logic              bank_switched;

	modport source (output valid, pixel_word, byte_count, window_offset, bank_number,
		bank_switched, input ready);
	modport sink   (input valid, pixel_word, byte_count, window_offset, bank_number,
		bank_switched, output ready);
endinterface
`default_nettype wire

// ===== src/bpw_cfg_if.sv =====
`default_nettype none
interface bpw_cfg_if;
	import bpw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/bpw_front.sv =====
`default_nettype none
module bpw_front
	import bpw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	bpw_pixel_if.sink     pixel,
	input  wire bpw_cfg_t cfg,
	input  wire logic     q_full,
	output bpw_push_t     push
);

	logic               valid_s1;
	logic [COORD_W-1:0] pos_x_s1;
	logic [COORD_W-1:0] pos_y_s1;
	logic [7:0]         red_s1;
	logic [7:0]         green_s1;
	logic [7:0]         blue_s1;

	logic              on_screen;
	logic [BPP_W-1:0]  bpp;
	logic [27:0]       prod;
	logic [14:0]       xb;
	logic [SUM_W-1:0]  sum;
	logic [31:0]       color;

	always_comb begin
		on_screen = !pos_x_s1[COORD_W-1] && !pos_y_s1[COORD_W-1]
			&& (pos_x_s1 < COORD_W'(cfg.screen_width))
			&& (pos_y_s1 < COORD_W'(cfg.screen_height));

		if (cfg.bytes_per_pixel == '0) begin
			bpp = BPP_W'(1);
		end else if (cfg.bytes_per_pixel > BPP_W'(4)) begin
			bpp = BPP_W'(4);
		end else begin
			bpp = cfg.bytes_per_pixel;
		end

		// only used on screen, so the coordinates fit in SCR_W bits
		prod = 28'(pos_y_s1[SCR_W-1:0]) * 28'(cfg.line_pitch);
		xb   = 15'(pos_x_s1[SCR_W-1:0]) * 15'(bpp);
		sum  = SUM_W'(prod) + SUM_W'(xb);

		color = place_component(red_s1, cfg.color_layout[4:0], cfg.color_layout[19:15])
			| place_component(green_s1, cfg.color_layout[9:5], cfg.color_layout[24:20])
			| place_component(blue_s1, cfg.color_layout[14:10], cfg.color_layout[29:25]);
	end

	assign push.valid       = valid_s1 && on_screen;
	assign push.item.color  = color;
	assign push.item.bpp    = bpp;
	assign push.item.offset = sum[OFFSET_BITS-1:0];

	// off-screen pixels drain without touching the queue
	assign pixel.ready = !valid_s1 || !on_screen || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			pos_x_s1 <= pixel.pos_x;
			pos_y_s1 <= pixel.pos_y;
			red_s1   <= pixel.red;
			green_s1 <= pixel.green;
			blue_s1  <= pixel.blue;
		end
	end

endmodule
`default_nettype wire

// ===== src/bpw_queue.sv =====
`default_nettype none
module bpw_queue
	import bpw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bpw_push_t push,
	output logic           full,
	output bpw_head_t      head,
	input  wire logic      pop
);

	bpw_item_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full           = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.not_empty = (cnt_q != '0);
	assign head.item      = entries_q[rd_ptr_q];
	assign do_push        = push.valid && !full;
	assign do_pop         = pop && head.not_empty;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.item;
		end
	end

endmodule
`default_nettype wire

// ===== src/bpw_back.sv =====
`default_nettype none
module bpw_back
	import bpw_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bpw_cfg_t  cfg,
	input  wire bpw_head_t head,
	output logic           pop,
	bpw_result_if.source   result
);

	back_state_t state_q, state_d;

	logic [WIN_BITS-1:0]  win_start_q;
	logic [WIN_BITS-1:0]  win_end_q;
	logic [BANK_W-1:0]    bank_q;
	bpw_item_t            item_q;
	logic [KB_W-1:0]      div_q;
	logic [KB_W-1:0]      rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic              out_valid_q;
	logic [31:0]       out_word_q;
	logic [BPP_W-1:0]  out_bpp_q;
	logic [WOFF_W-1:0] out_woff_q;
	logic [BANK_W-1:0] out_bank_q;
	logic              out_sw_q;

	logic                out_free;
	logic [WIN_BITS-1:0] head_off;
	logic                in_window;
	logic [KB_W:0]       shifted;
	logic                ge;
	logic [KB_W-1:0]     rem_nxt;
	logic [DIV_W-1:0]    start_hi;
	logic [WIN_BITS-1:0] new_start;
	logic [WIN_BITS:0]   end_sum;
	logic [WIN_BITS-1:0] new_end;
	logic [WIN_BITS-1:0] item_off;

	logic load_hit;
	logic load_div;
	logic div_step;
	logic emit_switch;

	assign out_free  = !out_valid_q || result.ready;
	assign head_off  = WIN_BITS'(head.item.offset);
	assign in_window = (head_off >= win_start_q) && (head_off < win_end_q);

	// restoring divide of offset/1024 by the granule count
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge      = (shifted >= {1'b0, div_q});
	assign rem_nxt = ge ? KB_W'(shifted - {1'b0, div_q}) : shifted[KB_W-1:0];

	// window start = (offset/1024 - remainder) * 1024
	assign item_off  = WIN_BITS'(item_q.offset);
	assign start_hi  = item_q.offset[OFFSET_BITS-1:KB_SHIFT] - DIV_W'(rem_q);
	assign new_start = WIN_BITS'({start_hi, KB_SHIFT'(0)});
	assign end_sum   = (WIN_BITS + 1)'(new_start)
		+ (WIN_BITS + 1)'({cfg.window_kb, KB_SHIFT'(0)});
	assign new_end   = end_sum[WIN_BITS] ? '1 : end_sum[WIN_BITS-1:0];

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		load_hit    = 1'b0;
		load_div    = 1'b0;
		div_step    = 1'b0;
		emit_switch = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (head.not_empty && out_free) begin
					pop = 1'b1;
					if (in_window) begin
						load_hit = 1'b1;
					end else begin
						load_div = 1'b1;
						state_d  = B_DIV;
					end
				end
			end
			B_DIV: begin
				div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (out_free) begin
					emit_switch = 1'b1;
					state_d     = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			win_start_q <= '0;
			win_end_q   <= WIN_BITS'({RST_WINDOW_KB, KB_SHIFT'(0)});
			bank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_switch) begin
				win_start_q <= new_start;
				win_end_q   <= new_end;
				bank_q      <= BANK_W'(WIN_BITS'(quo_q));
			end
			if (load_hit || emit_switch) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			item_q <= head.item;
			quo_q  <= head.item.offset[OFFSET_BITS-1:KB_SHIFT];
			rem_q  <= '0;
			cnt_q  <= '0;
			div_q  <= (cfg.granule_kb == '0) ? KB_W'(1) : cfg.granule_kb;
		end else if (div_step) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIV_W-2:0], ge};
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
		if (load_hit) begin
			out_word_q <= head.item.color;
			out_bpp_q  <= head.item.bpp;
			out_woff_q <= WOFF_W'(head_off - win_start_q);
			out_bank_q <= bank_q;
			out_sw_q   <= 1'b0;
		end else if (emit_switch) begin
			out_word_q <= item_q.color;
			out_bpp_q  <= item_q.bpp;
			out_woff_q <= WOFF_W'(item_off - new_start);
			out_bank_q <= BANK_W'(WIN_BITS'(quo_q));
			out_sw_q   <= 1'b1;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pixel_word    = out_word_q;
	assign result.byte_count    = out_bpp_q;
	assign result.window_offset = out_woff_q;
	assign result.bank_number   = out_bank_q;
	assign result.bank_switched = out_sw_q;

endmodule
`default_nettype wire

// ===== src/banked_pixel_writer_core.sv =====
// Banked pixel writer: each pixel transaction is checked against the screen, packed into a
// colour word and given a byte offset (y * pitch + x * bytes per pixel) by a registered
// front stage; off-screen pixels are dropped there with no result. A two-entry queue
// feeds the back end; a pixel in the current bank window leaves via its output register
// once that is free, so such writes stream at one per cycle while results are taken. A
// pixel off the window runs the bank divider, one quotient bit per cycle for the
// OFFSET_BITS - 10 bits of offset / 1024, and leaves via the emit state, taking no new
// pixel meanwhile; the divider sets the rate when banks switch often. Registers are
// written through the always-ready cfg channel; the user must write them only while no
// pixel is in flight (not enforced). New granule and window sizes apply at the next switch.
`default_nettype none
module banked_pixel_writer_core
	import bpw_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	bpw_cfg_if.sink      cfg,
	bpw_pixel_if.sink    pixel,
	bpw_result_if.source result
);

	bpw_cfg_t  cfg_q;
	bpw_push_t push;
	bpw_head_t head;
	logic      q_full;
	logic      pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width    <= RST_SCREEN_WIDTH;
			cfg_q.screen_height   <= RST_SCREEN_HEIGHT;
			cfg_q.line_pitch      <= RST_LINE_PITCH;
			cfg_q.bytes_per_pixel <= RST_BPP;
			cfg_q.granule_kb      <= RST_GRANULE_KB;
			cfg_q.window_kb       <= RST_WINDOW_KB;
			cfg_q.color_layout    <= RST_COLOR_LAYOUT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_SCREEN_WIDTH:    cfg_q.screen_width    <= cfg.data[SCR_W-1:0];
				CFG_SCREEN_HEIGHT:   cfg_q.screen_height   <= cfg.data[SCR_W-1:0];
				CFG_LINE_PITCH:      cfg_q.line_pitch      <= cfg.data[PITCH_W-1:0];
				CFG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg.data[BPP_W-1:0];
				CFG_GRANULE_KB:      cfg_q.granule_kb      <= cfg.data[KB_W-1:0];
				CFG_WINDOW_KB:       cfg_q.window_kb       <= cfg.data[KB_W-1:0];
				CFG_COLOR_LAYOUT:    cfg_q.color_layout    <= cfg.data[LAYOUT_W-1:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	bpw_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push)
	);

	bpw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	bpw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== src/bpw_checker.sv =====
`default_nettype none
module bpw_checker
	import bpw_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [31:0]       res_word,
	input wire logic [BPP_W-1:0]  res_bpp,
	input wire logic [WOFF_W-1:0] res_woff,
	input wire logic [BANK_W-1:0] res_bank,
	input wire logic              res_sw
);

	// a stalled result keeps its payload
	property p_hold;
		@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word) && $stable(res_bpp)
			&& $stable(res_woff) && $stable(res_bank) && $stable(res_sw);
	endproperty
	a_hold: assert property (p_hold) else $error("result changed while stalled");

	// byte count is always clamped to one through four
	property p_bpp;
		@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_bpp != 3'd0) && (res_bpp <= 3'd4);
	endproperty
	a_bpp: assert property (p_bpp) else $error("byte count out of range");

	// no result is valid right after reset
	property p_reset;
		@(posedge clk) !arst_n |=> !res_valid;
	endproperty
	a_reset: assert property (p_reset) else $error("result valid right after reset");

endmodule

bind banked_pixel_writer_core bpw_checker u_bpw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_word  (result.pixel_word),
	.res_bpp   (result.byte_count),
	.res_woff  (result.window_offset),
	.res_bank  (result.bank_number),
	.res_sw    (result.bank_switched)
);
`default_nettype wire
